/* rtl/sobel_edge_from_rgb_macros.svh */
// ----------------------------------------------------------------------------
// Sobel edge from RGB: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_FROM_RGB_MACROS_SVH
`define SOBEL_EDGE_FROM_RGB_MACROS_SVH

// same-cycle implication
`define SEDGE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SEDGE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sedge_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel edge from RGB: package
// Field widths, gray weights, register indexes and the result group type.
// ----------------------------------------------------------------------------
package sedge_pkg;

    localparam int GRAY_W        = 8;
    localparam int ROW_W         = 11;
    localparam int COL_OUT_W     = 11;
    localparam int CFG_W         = 12;
    localparam int NUM_RES       = 4;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = 3;
    localparam int FIFO_CW       = 4;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [15:0] WT_BLUE  = 16'd4732;
    localparam logic [15:0] WT_GREEN = 16'd46872;
    localparam logic [15:0] WT_RED   = 16'd13933;

    localparam logic [GRAY_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [GRAY_W-1:0]    val3;
        logic [GRAY_W-1:0]    val2;
        logic [GRAY_W-1:0]    val1;
        logic [GRAY_W-1:0]    val0;
        logic [NUM_RES-1:0]   mask;
    } sedge_group_t;

endpackage

/* rtl/sedge_ram.sv */
// ----------------------------------------------------------------------------
// Sobel edge from RGB: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sedge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/sobel_edge_from_rgb.sv */
// ----------------------------------------------------------------------------
// Sobel edge from RGB: top level
// Gray conversion, two-row line memory, 3x3 Sobel L1 magnitude, result queue.
// ----------------------------------------------------------------------------
// Takes one BGR pixel request per clock while pix_ready is high and reports
// tagged results from an eight-entry queue, one result per clock while
// res_ready is high. A pixel causes zero to four results: one inside a row,
// two at a row end and in the last row, up to four at the frame end; while
// the queue drains the extra results, pix_ready may drop. A pixel passes the
// capture, gray product and window stages before its results are queued. Both
// rows above sit in one 16-bit wide line memory of MAX_WIDTH entries, read at
// the request and written back from stage 2; a write that lands as the same
// column is read is forwarded. The line memory needs no clearing after reset.
// A write to frame_width or frame_height restarts the frame at row 0, column 0.
`include "sobel_edge_from_rgb_macros.svh"

module sobel_edge_from_rgb
    import sedge_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  logic [GRAY_W-1:0]    blue,
    input  logic [GRAY_W-1:0]    green,
    input  logic [GRAY_W-1:0]    red,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [ROW_W-1:0]     out_row,
    output logic [COL_OUT_W-1:0] out_col,
    output logic [GRAY_W-1:0]    edge_value,
    output logic                 last_of_run
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_BITS = COL_W + 1;
    localparam int LINE_W = 2 * GRAY_W;

    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    logic [W_BITS-1:0] w_eff;
    logic [CFG_W-1:0]  h_eff;

    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic              col_last;
    logic              row_last;
    logic              pix_accept;

    logic                s1_valid_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [NUM_RES-1:0]  s1_mask_reg;
    logic                s1_border_reg;
    logic [GRAY_W-1:0]   s1_blue_reg;
    logic [GRAY_W-1:0]   s1_green_reg;
    logic [GRAY_W-1:0]   s1_red_reg;
    logic [LINE_W-1:0]   line_rdata;
    logic [LINE_W-1:0]   line_fwd;

    logic                fwd_valid_reg;
    logic [COL_W-1:0]    fwd_addr_reg;
    logic [LINE_W-1:0]   fwd_data_reg;

    logic                s2_valid_reg;
    logic [ROW_W-1:0]    s2_row_reg;
    logic [COL_W-1:0]    s2_col_reg;
    logic [NUM_RES-1:0]  s2_mask_reg;
    logic                s2_border_reg;
    logic [23:0]         s2_prod_b_reg;
    logic [23:0]         s2_prod_g_reg;
    logic [23:0]         s2_prod_r_reg;
    logic [GRAY_W-1:0]   s2_top_reg;
    logic [GRAY_W-1:0]   s2_mid_reg;
    logic [23:0]         gray_sum;
    logic [GRAY_W-1:0]   s2_cur;

    logic [GRAY_W-1:0]   win_reg [6];

    logic                s3_valid_reg;
    logic [ROW_W-1:0]    s3_row_reg;
    logic [COL_OUT_W-1:0] s3_col_reg;
    logic [NUM_RES-1:0]  s3_mask_reg;
    logic                s3_border_reg;
    logic [GRAY_W-1:0]   g11_reg, g21_reg, g31_reg, g12_reg, g32_reg;
    logic [GRAY_W-1:0]   g13_reg, g23_reg, g33_reg, gb_reg;
    logic [9:0]          sx_pos, sx_neg, sy_pos, sy_neg;
    logic [9:0]          abs_x, abs_y;
    logic [10:0]         mag;
    logic [GRAY_W-1:0]   s3_val0;

    sedge_group_t        fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  fifo_count_reg;
    logic [FIFO_CW-1:0]  occupancy;
    logic                fifo_push;
    logic                fifo_pop;
    sedge_group_t        head;
    logic [NUM_RES-1:0]  done_reg;
    logic [NUM_RES-1:0]  pending;
    logic [NUM_RES-1:0]  sel;
    logic                res_accept;

    // ------------------------------------------------------------------
    // Configuration and frame position
    // ------------------------------------------------------------------
    always_comb
    begin
        if (frame_width_reg < 12'd2)
        begin
            w_eff = W_BITS'(2);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = W_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_BITS'(frame_width_reg);
        end

        if (frame_height_reg < 12'd2)
        begin
            h_eff = 12'd2;
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
    end

    assign pix_accept = pix_valid && pix_ready;
    assign col_last   = ({1'b0, col_reg} == (w_eff - W_BITS'(1)));
    assign row_last   = ({1'b0, row_reg} == (h_eff - 12'd1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 11'd1;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            row_reg          <= '0;
            col_reg          <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: {row two above, row above} per column
    // ------------------------------------------------------------------
    sedge_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_col_reg),
        .wdata ({s2_mid_reg, s2_cur}),
        .re    (pix_accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    assign line_fwd = (fwd_valid_reg && (fwd_addr_reg == s1_col_reg)) ? fwd_data_reg
                                                                       : line_rdata;

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= pix_accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            fwd_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                win_reg[3] <= win_reg[0];
                win_reg[4] <= win_reg[1];
                win_reg[5] <= win_reg[2];
                win_reg[0] <= s2_top_reg;
                win_reg[1] <= s2_mid_reg;
                win_reg[2] <= s2_cur;
            end
        end
    end

    assign gray_sum = s2_prod_b_reg + s2_prod_g_reg + s2_prod_r_reg;
    assign s2_cur   = gray_sum[23:16];

    always_ff @(posedge clk)
    begin
        // stage 1: capture request
        s1_row_reg    <= row_reg;
        s1_col_reg    <= col_reg;
        s1_mask_reg   <= {row_last && col_last,
                          row_last && (col_reg != '0),
                          (row_reg != '0) && col_last,
                          (row_reg != '0) && (col_reg != '0)};
        s1_border_reg <= (row_reg == 11'd1) || (col_reg == COL_W'(1));
        s1_blue_reg   <= blue;
        s1_green_reg  <= green;
        s1_red_reg    <= red;

        // stage 2: gray products and line data
        s2_row_reg    <= s1_row_reg;
        s2_col_reg    <= s1_col_reg;
        s2_mask_reg   <= s1_mask_reg;
        s2_border_reg <= s1_border_reg;
        s2_prod_b_reg <= 24'(WT_BLUE) * 24'(s1_blue_reg);
        s2_prod_g_reg <= 24'(WT_GREEN) * 24'(s1_green_reg);
        s2_prod_r_reg <= 24'(WT_RED) * 24'(s1_red_reg);
        s2_top_reg    <= line_fwd[LINE_W-1:GRAY_W];
        s2_mid_reg    <= line_fwd[GRAY_W-1:0];

        fwd_addr_reg  <= s2_col_reg;
        fwd_data_reg  <= {s2_mid_reg, s2_cur};

        // stage 3: window snapshot
        s3_row_reg    <= s2_row_reg;
        s3_col_reg    <= COL_OUT_W'(s2_col_reg);
        s3_mask_reg   <= s2_mask_reg;
        s3_border_reg <= s2_border_reg;
        g11_reg       <= win_reg[3];
        g21_reg       <= win_reg[4];
        g31_reg       <= win_reg[5];
        g12_reg       <= win_reg[0];
        g32_reg       <= win_reg[2];
        gb_reg        <= win_reg[1];
        g13_reg       <= s2_top_reg;
        g23_reg       <= s2_mid_reg;
        g33_reg       <= s2_cur;
    end

    // ------------------------------------------------------------------
    // Sobel L1 magnitude
    // ------------------------------------------------------------------
    always_comb
    begin
        sx_pos = {2'b0, g13_reg} + {1'b0, g23_reg, 1'b0} + {2'b0, g33_reg};
        sx_neg = {2'b0, g11_reg} + {1'b0, g21_reg, 1'b0} + {2'b0, g31_reg};
        sy_pos = {2'b0, g11_reg} + {1'b0, g12_reg, 1'b0} + {2'b0, g13_reg};
        sy_neg = {2'b0, g31_reg} + {1'b0, g32_reg, 1'b0} + {2'b0, g33_reg};
        abs_x  = (sx_pos >= sx_neg) ? sx_pos - sx_neg : sx_neg - sx_pos;
        abs_y  = (sy_pos >= sy_neg) ? sy_pos - sy_neg : sy_neg - sy_pos;
        mag    = {1'b0, abs_x} + {1'b0, abs_y};
        if (s3_border_reg)
        begin
            s3_val0 = gb_reg;
        end
        else if (mag > 11'(PIX_MAX))
        begin
            s3_val0 = PIX_MAX;
        end
        else
        begin
            s3_val0 = mag[GRAY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result queue: one group per pixel with results, unpacked one result per request
    // ------------------------------------------------------------------
    assign occupancy  = fifo_count_reg + FIFO_CW'(s1_valid_reg) + FIFO_CW'(s2_valid_reg)
                      + FIFO_CW'(s3_valid_reg);
    assign pix_ready  = (occupancy < FIFO_CW'(FIFO_DEPTH));
    assign fifo_push  = s3_valid_reg && (s3_mask_reg != '0);

    assign head       = fifo_mem_reg[rd_ptr_reg];
    assign pending    = head.mask & ~done_reg;
    assign res_valid  = (fifo_count_reg != '0);
    assign res_accept = res_valid && res_ready;

    always_comb
    begin
        priority if (pending[0])
        begin
            sel        = 4'b0001;
            out_row    = head.row - 11'd1;
            out_col    = head.col - 11'd1;
            edge_value = head.val0;
        end
        else if (pending[1])
        begin
            sel        = 4'b0010;
            out_row    = head.row - 11'd1;
            out_col    = head.col;
            edge_value = head.val1;
        end
        else if (pending[2])
        begin
            sel        = 4'b0100;
            out_row    = head.row;
            out_col    = head.col - 11'd1;
            edge_value = head.val2;
        end
        else
        begin
            sel        = 4'b1000;
            out_row    = head.row;
            out_col    = head.col;
            edge_value = head.val3;
        end
    end

    assign last_of_run = ((pending & ~sel) == '0);
    assign fifo_pop    = res_accept && last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            done_reg       <= '0;
        end
        else
        begin
            if (fifo_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
                done_reg   <= '0;
            end
            else if (res_accept)
            begin
                done_reg <= done_reg | sel;
            end
            unique case ({fifo_push, fifo_pop})
                2'b10:   fifo_count_reg <= fifo_count_reg + FIFO_CW'(1);
                2'b01:   fifo_count_reg <= fifo_count_reg - FIFO_CW'(1);
                default: fifo_count_reg <= fifo_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= '{row:  s3_row_reg,
                                          col:  s3_col_reg,
                                          val3: g33_reg,
                                          val2: g32_reg,
                                          val1: g23_reg,
                                          val0: s3_val0,
                                          mask: s3_mask_reg};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SEDGE_ASSERT_IMP(a_queue_credit, 1'b1, occupancy <= FIFO_CW'(FIFO_DEPTH),
                      "result queue overcommitted")
    `SEDGE_ASSERT_IMP(a_head_pending, res_valid, pending != '0,
                      "queue head has no result left")
    `SEDGE_ASSERT_NXT(a_cfg_restart, cfg_write, (row_reg == '0) && (col_reg == '0),
                      "frame position not restarted by register write")

endmodule

/* tb/sobel_edge_from_rgb_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// Sobel edge from RGB testbench
// ----------------------------------------------------------------------------
// Streams BGR pixel requests into sobel_edge_from_rgb under bursty input and
// a shifting output stall pattern. A behavioral edge predictor (gray weights,
// two line stores, six window registers, row/column position) computes the
// tagged results of every accepted request; each result taken from the block
// is compared field by field against the oldest prediction. Frame geometry
// covers the reset size, 2x2 and 3x3 frames, clamped out-of-range values, the
// start of the widest and tallest frames, restarts on register writes, and
// random frames of small sizes with random, saturated and smooth pixel content.
// ============================================================================
module sobel_edge_from_rgb_tb;
    import sedge_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 24;
    localparam int TIMEOUT_CYCLES = 2000;
    localparam int RANDOM_ITEMS   = 240;
    localparam int EDGE_ITEMS     = 64;
    localparam int GRAY_WT_B      = 4732;
    localparam int GRAY_WT_G      = 46872;
    localparam int GRAY_WT_R      = 13933;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [GRAY_W-1:0]    value;
        logic                 is_last;
    } edge_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [0:0]           cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_ready;
    logic [GRAY_W-1:0]    blue = '0;
    logic [GRAY_W-1:0]    green = '0;
    logic [GRAY_W-1:0]    red = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic [GRAY_W-1:0]    edge_value;
    logic                 last_of_run;

    edge_result_t     expected_edges[$];
    int               fail_count = 0;
    int               idle_cycles = 0;
    int               burst_left = 0;

    logic [CFG_W-1:0] width_setting = RESET_WIDTH;
    logic [CFG_W-1:0] height_setting = RESET_HEIGHT;
    bit [GRAY_W-1:0]  line_above [DEF_MAX_WIDTH];
    bit [GRAY_W-1:0]  line_two_above [DEF_MAX_WIDTH];
    bit [GRAY_W-1:0]  win [6];
    int unsigned      next_row = 0;
    int unsigned      next_col = 0;

    int               stall_mode = 0;
    int               stall_left = 0;
    int unsigned      stall_phase = 0;

    sobel_edge_from_rgb uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .edge_value  (edge_value),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic void queue_result(input int unsigned row, input int unsigned col,
                                         input logic [GRAY_W-1:0] value, input bit is_last);
        edge_result_t e;
        e.row     = ROW_W'(row);
        e.col     = COL_OUT_W'(col);
        e.value   = value;
        e.is_last = is_last;
        expected_edges.push_back(e);
    endfunction

    function automatic void predict_edges(input logic [GRAY_W-1:0] b, g, r);
        int unsigned     w, h, rw, cl;
        int              sum, gx, gy, mag;
        bit [GRAY_W-1:0] cur, top, mid, inner;
        bit              e0, e1, e2, e3;
        w  = clamp_size(width_setting, DEF_MAX_WIDTH);
        h  = clamp_size(height_setting, MAX_HEIGHT);
        rw = (next_row >= h) ? 0 : next_row;
        cl = (next_col >= w) ? 0 : next_col;
        sum = GRAY_WT_B * int'(b) + GRAY_WT_G * int'(g) + GRAY_WT_R * int'(r);
        cur = GRAY_W'(sum >> 16);
        top = line_two_above[cl];
        mid = line_above[cl];
        line_two_above[cl] = mid;
        line_above[cl]     = cur;
        e0 = (rw >= 1) && (cl >= 1);
        e1 = (rw >= 1) && (cl == w - 1);
        e2 = (rw == h - 1) && (cl >= 1);
        e3 = (rw == h - 1) && (cl == w - 1);
        if (e0)
        begin
            if (rw == 1 || cl == 1)
                inner = win[1];
            else
            begin
                gx = (int'(top) + 2 * int'(mid) + int'(cur))
                   - (int'(win[3]) + 2 * int'(win[4]) + int'(win[5]));
                gy = (int'(win[3]) + 2 * int'(win[0]) + int'(top))
                   - (int'(win[5]) + 2 * int'(win[2]) + int'(cur));
                mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                inner = (mag > 255) ? PIX_MAX : GRAY_W'(mag);
            end
            queue_result(rw - 1, cl - 1, inner, !(e1 || e2 || e3));
        end
        if (e1)
            queue_result(rw - 1, cl, mid, !(e2 || e3));
        if (e2)
            queue_result(rw, cl - 1, win[2], !e3);
        if (e3)
            queue_result(rw, cl, cur, 1'b1);
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top;
        win[1] = mid;
        win[2] = cur;
        cl++;
        if (cl >= w)
        begin
            cl = 0;
            rw++;
            if (rw >= h)
                rw = 0;
        end
        next_row = rw;
        next_col = cl;
    endfunction

    function automatic logic [3*GRAY_W-1:0] random_bgr(input int style);
        logic [3*GRAY_W-1:0] px;
        case (style)
            1: px = {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                     {8{1'($urandom_range(0, 1))}}};
            2: px = {8'($urandom_range(96, 104)), 8'($urandom_range(96, 104)),
                     8'($urandom_range(96, 104))};
            default: px = 24'($urandom);
        endcase
        return px;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size(input int unsigned hi);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return CFG_W'(pick);
        if (pick < 14)
            return CFG_W'($urandom_range(2, 6));
        return CFG_W'($urandom_range(7, hi));
    endfunction

    task automatic send_pixel(input logic [3*GRAY_W-1:0] px);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_valid <= 1'b1;
        blue      <= px[23:16];
        green     <= px[15:8];
        red       <= px[7:0];
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        predict_edges(px[23:16], px[15:8], px[7:0]);
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        bit width_first;
        width_first = 1'($urandom_range(0, 1));
        cfg_write <= 1'b1;
        cfg_index <= width_first ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT;
        cfg_data  <= width_first ? w : h;
        @(posedge clk);
        cfg_index <= width_first ? REG_FRAME_HEIGHT : REG_FRAME_WIDTH;
        cfg_data  <= width_first ? h : w;
        @(posedge clk);
        cfg_write <= 1'b0;
        width_setting  = w;
        height_setting = h;
        next_row = 0;
        next_col = 0;
    endtask

    task automatic test_reset_geometry();
        repeat (6) send_pixel(random_bgr(0));
        wait_drained();
    endtask

    task automatic test_tiny_frames();
        logic [3*GRAY_W-1:0] tiny_px [8] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                            24'h0000FF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};
        write_geometry(12'd2, 12'd2);
        foreach (tiny_px[i])
            send_pixel(tiny_px[i]);
        wait_drained();
        write_geometry(12'd3, 12'd3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 3 == 0) ? 24'hFFFFFF : 24'h000000);
        wait_drained();
    endtask

    task automatic test_clamped_geometry();
        write_geometry(12'd1, 12'd0);
        repeat (5) send_pixel(random_bgr(1));
        wait_drained();
        write_geometry(12'd0, 12'd1);
        repeat (3) send_pixel(random_bgr(0));
        wait_drained();
    endtask

    task automatic test_frame_restart();
        write_geometry(12'd4, 12'd3);
        repeat (6) send_pixel(random_bgr(0));
        wait_drained();
        write_geometry(12'd4, 12'd3);
        repeat (12) send_pixel(random_bgr(0));
        wait_drained();
    endtask

    task automatic test_widest_row();
        write_geometry(12'hFFF, 12'd2);
        repeat (EDGE_ITEMS) send_pixel(random_bgr($urandom_range(0, 2)));
        wait_drained();
    endtask

    task automatic test_tallest_column();
        write_geometry(12'd2, 12'hFFF);
        repeat (EDGE_ITEMS) send_pixel(random_bgr($urandom_range(0, 2)));
        wait_drained();
    endtask

    task automatic test_random_frames();
        int          sent, pixels, style;
        int unsigned w, h;
        logic [CFG_W-1:0] w_set, h_set;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w_set = pick_size(24);
            h_set = pick_size(10);
            w = clamp_size(w_set, DEF_MAX_WIDTH);
            h = clamp_size(h_set, MAX_HEIGHT);
            wait_drained();
            write_geometry(w_set, h_set);
            pixels = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
            if (pixels > RANDOM_ITEMS - sent)
                pixels = RANDOM_ITEMS - sent;
            style  = $urandom_range(0, 2);
            repeat (pixels)
            begin
                send_pixel(random_bgr(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                                                   : style));
                sent++;
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(64, 256);
            stall_phase <= 0;
        end
        else
        begin
            stall_left  <= stall_left - 1;
            stall_phase <= stall_phase + 1;
        end
        case (stall_mode)
            1: res_ready <= ($urandom_range(0, 9) < 6);
            2: res_ready <= (stall_phase % 3 != 0);
            3: res_ready <= (stall_phase % 16 >= 12);
            default: res_ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin : check_results
        edge_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_edges.size() == 0)
            begin
                $error("result at row %0d col %0d with no request pending", out_row, out_col);
                fail_count++;
            end
            else
            begin
                want = expected_edges.pop_front();
                if (out_row !== want.row)
                begin
                    $error("out_row: expected %0d, got %0d", want.row, out_row);
                    fail_count++;
                end
                if (out_col !== want.col)
                begin
                    $error("out_col: expected %0d, got %0d", want.col, out_col);
                    fail_count++;
                end
                if (edge_value !== want.value)
                begin
                    $error("edge_value: expected %0d, got %0d", want.value, edge_value);
                    fail_count++;
                end
                if (last_of_run !== want.is_last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.is_last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= TIMEOUT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_tiny_frames();
        test_clamped_geometry();
        test_frame_restart();
        test_widest_row();
        test_tallest_column();
        test_random_frames();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_edges.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
